>>> rtl/pdh_pkg.sv
`timescale 1ns / 1ps
package pdh_pkg;

    localparam int MAX_ATOMS_DEF = 512;
    localparam int NUM_BINS_DEF  = 2048;
    localparam int NUM_TYPES_DEF = 4;

    localparam int COORD_W = 20;
    localparam int BOX_W   = 19;
    localparam int BINW_W  = 16;
    localparam int CNT_W   = 17;
    localparam int TYPE_W  = 2;
    localparam int STORE_W = TYPE_W + 3 * COORD_W;

    // arithmetic widths of the pair pipeline
    localparam int DIFF_W = COORD_W + 1;   // earlier - new
    localparam int NUM_W  = 22;            // dividend: 2*|d| or isqrt root
    localparam int IQ_W   = 21;            // reduced image index magnitude
    localparam int PROD_W = IQ_W + BOX_W;  // image shift
    localparam int XW_W   = PROD_W + 2;
    localparam int X_W    = 22;            // wrapped component
    localparam int SQ_W   = 44;            // squared distance
    localparam int ROOT_W = 22;
    localparam int SREM_W = 24;
    localparam int STEPS  = 22;            // divider and isqrt iterations
    localparam int STEP_W = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [BOX_W-1:0]  BOX_RST  = 19'd25240;
    localparam logic [BINW_W-1:0] BINW_RST = 16'd20;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [1:0]                atom_type;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [10:0]               bin_index;
        logic [3:0]                pair_kind;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] bin_count;
        logic [9:0]       atoms_stored;
        logic [1:0]       status;
        logic [CNT_W-1:0] dropped_total;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_READ_RD,
        OP_CLR_WR,
        OP_RD_ATOM,
        OP_AX_LOAD,
        OP_DIV_STEP,
        OP_MUL,
        OP_WRAP,
        OP_SQ,
        OP_ACC,
        OP_SQRT_LOAD,
        OP_SQRT_STEP,
        OP_BIN_LOAD,
        OP_HIST_RD,
        OP_HIST_WR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       store_wr;
        logic       result;
        logic [1:0] axis;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       full;
        logic       empty;
        logic       last_pair;
    } t_dp_stat;

endpackage

>>> rtl/pdh_ram.sv
`timescale 1ns / 1ps
module pdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pdh_dp.sv
`timescale 1ns / 1ps
module pdh_dp #(
    parameter int MAX_ATOMS = pdh_pkg::MAX_ATOMS_DEF,
    parameter int NUM_BINS  = pdh_pkg::NUM_BINS_DEF,
    parameter int NUM_TYPES = pdh_pkg::NUM_TYPES_DEF,
    localparam int AW         = $clog2(MAX_ATOMS),
    localparam int CW         = $clog2(MAX_ATOMS + 1),
    localparam int KINDS      = NUM_TYPES * NUM_TYPES,
    localparam int KW         = (KINDS > 1) ? $clog2(KINDS) : 1,
    localparam int BNW        = $clog2(NUM_BINS),
    localparam int HIST_DEPTH = NUM_BINS * KINDS,
    localparam int HAW        = $clog2(HIST_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pdh_pkg::t_dp_cmd              i_cmd,
    input  logic [AW-1:0]                 i_pair_idx,
    input  logic [HAW-1:0]                i_clr_addr,
    input  pdh_pkg::t_in_item             i_item,
    input  logic [pdh_pkg::BOX_W-1:0]     i_box_x,
    input  logic [pdh_pkg::BOX_W-1:0]     i_box_y,
    input  logic [pdh_pkg::BOX_W-1:0]     i_box_z,
    input  logic [pdh_pkg::BINW_W-1:0]    i_bin_width,
    output pdh_pkg::t_dp_stat             o_stat,
    output pdh_pkg::t_out_item            o_result
);
    import pdh_pkg::*;

    t_in_item  r_item;
    t_out_item r_result;
    logic [CW-1:0]    r_atom_count;
    logic [CNT_W-1:0] r_dropped;
    logic             r_drop_flag;
    logic             r_full_flag;

    logic signed [DIFF_W-1:0] r_d;
    logic                     r_neg;
    logic [BOX_W-1:0]         r_den;
    logic [NUM_W-1:0]         r_num;
    logic [BOX_W-1:0]         r_rem;
    logic [PROD_W-1:0]        r_prod;
    logic signed [X_W-1:0]    r_x;
    logic [SQ_W-1:0]          r_sq;
    logic [SQ_W-1:0]          r_acc;
    logic [ROOT_W-1:0]        r_root;
    logic [SREM_W-1:0]        r_srem;

    // atom store
    logic               s_we;
    logic [AW-1:0]      s_waddr;
    logic [STORE_W-1:0] s_wdata;
    logic               s_re;
    logic [STORE_W-1:0] s_rdata;

    // histogram
    logic             h_we;
    logic [HAW-1:0]   h_waddr;
    logic [CNT_W-1:0] h_wdata;
    logic             h_re;
    logic [HAW-1:0]   h_raddr;
    logic [CNT_W-1:0] h_rdata;

    logic [TYPE_W-1:0]         w_type;
    logic [TYPE_W-1:0]         w_st_type;
    logic signed [COORD_W-1:0] w_st_c;
    logic signed [COORD_W-1:0] w_pos_c;
    logic [BOX_W-1:0]          w_box_c;
    logic signed [DIFF_W-1:0]  w_d;
    logic [DIFF_W-1:0]         w_mag;
    logic [BOX_W:0]            w_trial;
    logic                      w_ge;
    logic [IQ_W-1:0]           w_iq;
    logic signed [XW_W-1:0]    w_xw;
    logic signed [SQ_W-1:0]    w_sq;
    logic [SREM_W+1:0]         w_srt;
    logic [SREM_W+1:0]         w_strial;
    logic                      w_sge;
    logic [BOX_W-1:0]          w_bw;
    logic                      w_drop;
    logic [KW-1:0]             w_kind;
    logic [HAW-1:0]            w_hist_addr;
    logic                      w_rd_ok;
    logic [HAW-1:0]            w_rd_addr;
    logic [CNT_W-1:0]          w_inc;

    assign w_type = (int'(r_item.atom_type) >= NUM_TYPES) ? TYPE_W'(NUM_TYPES - 1)
                                                          : r_item.atom_type;
    assign w_st_type = s_rdata[STORE_W-1 -: TYPE_W];

    always_comb begin
        w_st_c  = s_rdata[COORD_W*3-1 -: COORD_W];
        w_pos_c = r_item.pos_x;
        w_box_c = i_box_x;
        unique case (i_cmd.axis)
            AXIS_Y: begin
                w_st_c  = s_rdata[COORD_W*2-1 -: COORD_W];
                w_pos_c = r_item.pos_y;
                w_box_c = i_box_y;
            end
            AXIS_Z: begin
                w_st_c  = s_rdata[COORD_W-1:0];
                w_pos_c = r_item.pos_z;
                w_box_c = i_box_z;
            end
            default: ;
        endcase
    end

    assign w_d   = DIFF_W'(w_st_c) - DIFF_W'(w_pos_c);
    assign w_mag = (w_d < 0) ? DIFF_W'(-w_d) : DIFF_W'(w_d);

    // restoring divider, one quotient bit per step
    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    // image index i - trunc(i/2), on the magnitude
    assign w_iq    = IQ_W'(r_num - (r_num >> 1));
    assign w_xw    = r_neg ? (XW_W'(r_d) + signed'({2'b00, r_prod}))
                           : (XW_W'(r_d) - signed'({2'b00, r_prod}));
    assign w_sq    = SQ_W'(r_x) * SQ_W'(r_x);

    // isqrt, one root bit per step
    assign w_srt    = {r_srem, r_acc[SQ_W-1 -: 2]};
    assign w_strial = (SREM_W+2)'({r_root, 2'b01});
    assign w_sge    = w_srt >= w_strial;

    assign w_bw = (i_bin_width == '0) ? BOX_W'(1) : BOX_W'(i_bin_width);

    assign w_drop      = r_num >= NUM_W'(NUM_BINS);
    assign w_kind      = KW'(int'(w_st_type) * NUM_TYPES + int'(w_type));
    assign w_hist_addr = HAW'(int'(r_num[BNW-1:0]) * KINDS + int'(w_kind));
    assign w_rd_ok     = (int'(r_item.bin_index) < NUM_BINS)
                      && (int'(r_item.pair_kind) < KINDS);
    assign w_rd_addr   = HAW'(int'(r_item.bin_index) * KINDS + int'(r_item.pair_kind));
    assign w_inc       = (h_rdata == CNT_MAX) ? h_rdata : h_rdata + CNT_W'(1);

    assign s_we    = i_cmd.store_wr;
    assign s_waddr = AW'(r_atom_count);
    assign s_wdata = {w_type, r_item.pos_x, r_item.pos_y, r_item.pos_z};
    assign s_re    = i_cmd.op == OP_RD_ATOM;

    assign h_we    = (i_cmd.op == OP_CLR_WR) || (i_cmd.op == OP_HIST_WR && !w_drop);
    assign h_waddr = (i_cmd.op == OP_CLR_WR) ? i_clr_addr : w_hist_addr;
    assign h_wdata = (i_cmd.op == OP_CLR_WR) ? '0 : w_inc;
    assign h_re    = (i_cmd.op == OP_READ_RD) || (i_cmd.op == OP_HIST_RD && !w_drop);
    assign h_raddr = (i_cmd.op == OP_READ_RD) ? w_rd_addr : w_hist_addr;

    pdh_ram #(.WIDTH(STORE_W), .DEPTH(MAX_ATOMS)) u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (i_pair_idx),
        .o_rdata (s_rdata)
    );

    pdh_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_re    (h_re),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atom_count <= '0;
            r_dropped    <= '0;
            r_drop_flag  <= 1'b0;
            r_full_flag  <= 1'b0;
        end else begin
            if (i_cmd.store_wr) begin
                r_atom_count <= r_atom_count + CW'(1);
            end
            unique case (i_cmd.op)
                OP_LATCH: begin
                    r_drop_flag <= 1'b0;
                    r_full_flag <= r_atom_count >= CW'(MAX_ATOMS);
                end
                OP_CLR_WR: begin
                    r_atom_count <= '0;
                    r_dropped    <= '0;
                end
                OP_HIST_WR: begin
                    if (w_drop) begin
                        r_drop_flag <= 1'b1;
                        if (r_dropped != CNT_MAX) begin
                            r_dropped <= r_dropped + CNT_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LATCH: r_item <= i_item;
            OP_RD_ATOM: r_acc <= '0;
            OP_AX_LOAD: begin
                r_d   <= w_d;
                r_neg <= w_d < 0;
                r_num <= {w_mag, 1'b0};
                r_rem <= '0;
                r_den <= (w_box_c == '0) ? BOX_W'(1) : w_box_c;
            end
            OP_DIV_STEP: begin
                r_rem <= w_ge ? BOX_W'(w_trial - {1'b0, r_den}) : BOX_W'(w_trial);
                r_num <= {r_num[NUM_W-2:0], w_ge};
            end
            OP_MUL:  r_prod <= PROD_W'(w_iq) * PROD_W'(r_den);
            OP_WRAP: r_x    <= X_W'(w_xw);
            OP_SQ:   r_sq   <= SQ_W'(unsigned'(w_sq));
            OP_ACC:  r_acc  <= r_acc + r_sq;
            OP_SQRT_LOAD: begin
                r_root <= '0;
                r_srem <= '0;
            end
            OP_SQRT_STEP: begin
                r_srem <= w_sge ? SREM_W'(w_srt - w_strial) : SREM_W'(w_srt);
                r_root <= {r_root[ROOT_W-2:0], w_sge};
                r_acc  <= {r_acc[SQ_W-3:0], 2'b00};
            end
            OP_BIN_LOAD: begin
                r_num <= NUM_W'(r_root);
                r_rem <= '0;
                r_den <= w_bw;
            end
            default: ;
        endcase
        if (i_cmd.result) begin
            r_result.bin_count     <= (r_item.req_type == REQ_READ && w_rd_ok) ? h_rdata : '0;
            r_result.atoms_stored  <= 10'(r_atom_count);
            r_result.dropped_total <= r_dropped;
            if (r_item.req_type == REQ_ADD && r_full_flag) begin
                r_result.status <= ST_FULL;
            end else if (r_drop_flag) begin
                r_result.status <= ST_DROP;
            end else begin
                r_result.status <= ST_OK;
            end
        end
    end

    assign o_stat.req       = r_item.req_type;
    assign o_stat.full      = r_full_flag;
    assign o_stat.empty     = r_atom_count == '0;
    assign o_stat.last_pair = (CW'(i_pair_idx) + CW'(1)) == r_atom_count;
    assign o_result         = r_result;

endmodule

>>> rtl/pdh_ctrl.sv
`timescale 1ns / 1ps
module pdh_ctrl #(
    parameter int MAX_ATOMS = pdh_pkg::MAX_ATOMS_DEF,
    parameter int NUM_BINS  = pdh_pkg::NUM_BINS_DEF,
    parameter int NUM_TYPES = pdh_pkg::NUM_TYPES_DEF,
    localparam int AW         = $clog2(MAX_ATOMS),
    localparam int HIST_DEPTH = NUM_BINS * NUM_TYPES * NUM_TYPES,
    localparam int HAW        = $clog2(HIST_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  pdh_pkg::t_dp_stat i_stat,
    output pdh_pkg::t_dp_cmd  o_cmd,
    output logic [AW-1:0]     o_pair_idx,
    output logic [HAW-1:0]    o_clr_addr
);
    import pdh_pkg::*;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DISPATCH,
        S_PAIR_RD,
        S_AX_LOAD,
        S_AX_DIV,
        S_AX_MUL,
        S_AX_WRAP,
        S_AX_SQ,
        S_AX_ACC,
        S_SQ_LOAD,
        S_SQ_RUN,
        S_BIN_LOAD,
        S_BIN_DIV,
        S_HIST_RD,
        S_HIST_WR,
        S_STORE,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [HAW-1:0]     r_clr;
    logic               r_clr_reply;
    logic [AW-1:0]      r_k;
    logic [1:0]         r_axis;
    logic [STEP_W-1:0]  r_step;
    logic               r_out_valid;

    logic w_in_acc;
    logic w_out_free;
    logic w_last_step;

    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_last_step = r_step == STEP_W'(STEPS - 1);

    always_comb begin
        o_cmd.op       = OP_NONE;
        o_cmd.store_wr = 1'b0;
        o_cmd.result   = 1'b0;
        o_cmd.axis     = r_axis;
        unique case (r_state)
            S_CLR:      o_cmd.op = OP_CLR_WR;
            S_IDLE:     o_cmd.op = w_in_acc ? OP_LATCH : OP_NONE;
            S_DISPATCH: o_cmd.op = (i_stat.req == REQ_READ) ? OP_READ_RD : OP_NONE;
            S_PAIR_RD:  o_cmd.op = OP_RD_ATOM;
            S_AX_LOAD:  o_cmd.op = OP_AX_LOAD;
            S_AX_DIV:   o_cmd.op = OP_DIV_STEP;
            S_AX_MUL:   o_cmd.op = OP_MUL;
            S_AX_WRAP:  o_cmd.op = OP_WRAP;
            S_AX_SQ:    o_cmd.op = OP_SQ;
            S_AX_ACC:   o_cmd.op = OP_ACC;
            S_SQ_LOAD:  o_cmd.op = OP_SQRT_LOAD;
            S_SQ_RUN:   o_cmd.op = OP_SQRT_STEP;
            S_BIN_LOAD: o_cmd.op = OP_BIN_LOAD;
            S_BIN_DIV:  o_cmd.op = OP_DIV_STEP;
            S_HIST_RD:  o_cmd.op = OP_HIST_RD;
            S_HIST_WR:  o_cmd.op = OP_HIST_WR;
            S_STORE:    o_cmd.store_wr = 1'b1;
            S_DONE:     o_cmd.result = w_out_free;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_clr_reply <= 1'b0;
            r_k         <= '0;
            r_axis      <= AXIS_X;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    if (r_clr == HAW'(HIST_DEPTH - 1)) begin
                        r_clr       <= '0;
                        r_clr_reply <= 1'b0;
                        r_state     <= r_clr_reply ? S_DONE : S_IDLE;
                    end else begin
                        r_clr <= r_clr + HAW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    unique case (i_stat.req)
                        REQ_ADD: begin
                            r_k <= '0;
                            if (i_stat.full) begin
                                r_state <= S_DONE;
                            end else if (i_stat.empty) begin
                                r_state <= S_STORE;
                            end else begin
                                r_state <= S_PAIR_RD;
                            end
                        end
                        REQ_CLEAR: begin
                            r_clr_reply <= 1'b1;
                            r_state     <= S_CLR;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_PAIR_RD: begin
                    r_axis  <= AXIS_X;
                    r_state <= S_AX_LOAD;
                end
                S_AX_LOAD: begin
                    r_step  <= '0;
                    r_state <= S_AX_DIV;
                end
                S_AX_DIV: begin
                    r_step <= r_step + STEP_W'(1);
                    if (w_last_step) begin
                        r_state <= S_AX_MUL;
                    end
                end
                S_AX_MUL:  r_state <= S_AX_WRAP;
                S_AX_WRAP: r_state <= S_AX_SQ;
                S_AX_SQ:   r_state <= S_AX_ACC;
                S_AX_ACC: begin
                    if (r_axis == AXIS_Z) begin
                        r_state <= S_SQ_LOAD;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_AX_LOAD;
                    end
                end
                S_SQ_LOAD: begin
                    r_step  <= '0;
                    r_state <= S_SQ_RUN;
                end
                S_SQ_RUN: begin
                    r_step <= r_step + STEP_W'(1);
                    if (w_last_step) begin
                        r_state <= S_BIN_LOAD;
                    end
                end
                S_BIN_LOAD: begin
                    r_step  <= '0;
                    r_state <= S_BIN_DIV;
                end
                S_BIN_DIV: begin
                    r_step <= r_step + STEP_W'(1);
                    if (w_last_step) begin
                        r_state <= S_HIST_RD;
                    end
                end
                S_HIST_RD: r_state <= S_HIST_WR;
                S_HIST_WR: begin
                    if (i_stat.last_pair) begin
                        r_state <= S_STORE;
                    end else begin
                        r_k     <= r_k + AW'(1);
                        r_state <= S_PAIR_RD;
                    end
                end
                S_STORE: r_state <= S_DONE;
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_pair_idx  = r_k;
    assign o_clr_addr  = r_clr;

`ifndef SYNTH
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DISPATCH))
        else $error("accepted beat not dispatched");

    a_pairs_need_atoms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAIR_RD) |-> !i_stat.empty)
        else $error("pair loop started on empty store");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AX_DIV || r_state == S_SQ_RUN || r_state == S_BIN_DIV)
            |-> (r_step < STEP_W'(STEPS)))
        else $error("iteration counter overran");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("result overwrote a waiting beat");
`endif

endmodule

>>> rtl/pair_distance_histogram.sv
`timescale 1ns / 1ps
// Pair-distance histogram with minimum-image wrapping.
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one request beat:
// add an atom, read one histogram bin, or clear. Each request gives exactly
// one result beat on o_out_valid / i_out_stall / o_out_data.
// Add: the new atom is paired with each stored atom in turn. Each pair runs
// three 22-step axis divisions and a 22-step bin division on one shared
// divider, a 22-step isqrt, multiply/square stages and a read-modify-write
// of the histogram RAM. Read and a rejected add go from dispatch straight
// to their result.
// Clear sweeps the histogram RAM one entry a cycle over all
// NUM_BINS*NUM_TYPES^2 entries (32768 by default), then returns its result.
// Reset: the same sweep runs after reset, with o_in_stall high meanwhile;
// registers on the APB port return to their defaults and stay writable.
// The result sits in an output register; a new request is accepted while it
// waits, and the block holds before loading the next result until the
// receiver drops i_out_stall.
module pair_distance_histogram #(
    parameter int MAX_ATOMS = pdh_pkg::MAX_ATOMS_DEF,
    parameter int NUM_BINS  = pdh_pkg::NUM_BINS_DEF,
    parameter int NUM_TYPES = pdh_pkg::NUM_TYPES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pdh_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pdh_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pdh_pkg::*;

    localparam int AW         = $clog2(MAX_ATOMS);
    localparam int HIST_DEPTH = NUM_BINS * NUM_TYPES * NUM_TYPES;
    localparam int HAW        = $clog2(HIST_DEPTH);

    localparam logic [1:0] REG_BOX_X = 2'd0;
    localparam logic [1:0] REG_BOX_Y = 2'd1;
    localparam logic [1:0] REG_BOX_Z = 2'd2;
    localparam logic [1:0] REG_BIN_W = 2'd3;

    logic [BOX_W-1:0]  r_box_x;
    logic [BOX_W-1:0]  r_box_y;
    logic [BOX_W-1:0]  r_box_z;
    logic [BINW_W-1:0] r_bin_width;

    t_dp_cmd        w_cmd;
    t_dp_stat       w_stat;
    logic [AW-1:0]  w_pair_idx;
    logic [HAW-1:0] w_clr_addr;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x     <= BOX_RST;
            r_box_y     <= BOX_RST;
            r_box_z     <= BOX_RST;
            r_bin_width <= BINW_RST;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_BOX_X: r_box_x     <= pwdata[BOX_W-1:0];
                REG_BOX_Y: r_box_y     <= pwdata[BOX_W-1:0];
                REG_BOX_Z: r_box_z     <= pwdata[BOX_W-1:0];
                REG_BIN_W: r_bin_width <= pwdata[BINW_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BOX_X: prdata = 32'(r_box_x);
            REG_BOX_Y: prdata = 32'(r_box_y);
            REG_BOX_Z: prdata = 32'(r_box_z);
            REG_BIN_W: prdata = 32'(r_bin_width);
        endcase
    end

    pdh_ctrl #(
        .MAX_ATOMS (MAX_ATOMS),
        .NUM_BINS  (NUM_BINS),
        .NUM_TYPES (NUM_TYPES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_pair_idx  (w_pair_idx),
        .o_clr_addr  (w_clr_addr)
    );

    pdh_dp #(
        .MAX_ATOMS (MAX_ATOMS),
        .NUM_BINS  (NUM_BINS),
        .NUM_TYPES (NUM_TYPES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_pair_idx  (w_pair_idx),
        .i_clr_addr  (w_clr_addr),
        .i_item      (i_in_data),
        .i_box_x     (r_box_x),
        .i_box_y     (r_box_y),
        .i_box_z     (r_box_z),
        .i_bin_width (r_bin_width),
        .o_stat      (w_stat),
        .o_result    (o_out_data)
    );

endmodule

>>> dv/pair_distance_histogram_test.sv
`timescale 1ns / 1ps
module pair_distance_histogram_test;
    import pdh_pkg::*;

    localparam logic [1:0] REQ_NOP = 2'd3;
    localparam int NBINS = 2048;
    localparam int NKIND = 16;
    localparam logic [3:0] ADDR_BOX_X = 4'd0;
    localparam logic [3:0] ADDR_BOX_Y = 4'd4;
    localparam logic [3:0] ADDR_BOX_Z = 4'd8;
    localparam logic [3:0] ADDR_BINW  = 4'd12;

    class histo_scoreboard;
        int unsigned box[3];
        int unsigned bw;
        int signed   ax[$], ay[$], az[$];
        int unsigned atype[$];
        int unsigned hist[NBINS*NKIND];
        int unsigned dropped;
        t_out_item   expected_q[$];
        int          errors;
        int          n_checked;
        int          n_drops_seen;
        int          hit_bin;
        int          hit_kind;

        function void reset_state();
            box = '{25240, 25240, 25240};
            bw = 20;
            wipe();
        endfunction

        function void wipe();
            ax.delete(); ay.delete(); az.delete(); atype.delete();
            foreach (hist[i]) hist[i] = 0;
            dropped = 0;
        endfunction

        function void set_reg(int idx, int unsigned val);
            if (idx < 3) box[idx] = val & 32'h7FFFF;
            else bw = val & 32'hFFFF;
        endfunction

        function longint fold(longint d, int unsigned edge_len);
            longint b;
            longint img;
            b = (edge_len == 0) ? 1 : edge_len;
            img = (2 * d) / b;
            img = img - img / 2;
            return d - img * b;
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int s = 23; s >= 0; s--) begin
                t = r | (64'd1 << s);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            longint x, y, z;
            longint unsigned d2, n, w;
            int unsigned k;
            r = '0;
            case (it.req_type)
                REQ_ADD: begin
                    if (ax.size() >= 512) begin
                        r.status = ST_FULL;
                    end else begin
                        w = (bw == 0) ? 1 : bw;
                        foreach (ax[i]) begin
                            x = fold(longint'(ax[i]) - longint'(it.pos_x), box[0]);
                            y = fold(longint'(ay[i]) - longint'(it.pos_y), box[1]);
                            z = fold(longint'(az[i]) - longint'(it.pos_z), box[2]);
                            d2 = x * x + y * y + z * z;
                            n = root(d2) / w;
                            if (n >= NBINS) begin
                                if (dropped < 131071) dropped++;
                                n_drops_seen++;
                                r.status = ST_DROP;
                            end else begin
                                k = atype[i] * 4 + it.atom_type;
                                if (hist[n*NKIND+k] < 131071) hist[n*NKIND+k]++;
                                hit_bin = n;
                                hit_kind = k;
                            end
                        end
                        ax.push_back(it.pos_x);
                        ay.push_back(it.pos_y);
                        az.push_back(it.pos_z);
                        atype.push_back(it.atom_type);
                    end
                end
                REQ_READ: r.bin_count = hist[it.bin_index*NKIND + it.pair_kind];
                REQ_CLEAR: wipe();
                default: ;
            endcase
            r.atoms_stored = ax.size();
            r.dropped_total = dropped;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: %p", got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            n_checked++;
            if (got.bin_count !== e.bin_count) begin
                $error("bin_count exp %0d got %0d", e.bin_count, got.bin_count);
                errors++;
            end
            if (got.atoms_stored !== e.atoms_stored) begin
                $error("atoms_stored exp %0d got %0d", e.atoms_stored, got.atoms_stored);
                errors++;
            end
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status);
                errors++;
            end
            if (got.dropped_total !== e.dropped_total) begin
                $error("dropped_total exp %0d got %0d", e.dropped_total, got.dropped_total);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    histo_scoreboard sb;
    bit   no_idle;
    bit   long_hold;
    int   n_sent;
    int   n_adds;
    int   n_reads;
    logic signed [19:0] last_x, last_y, last_z;

    pair_distance_histogram u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #300_000_000;
        $display("FAIL");
        $finish;
    end

    // result side: random stall, plus one long hold on request
    initial begin
        int hold;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_out_stall <= 1'b1;
                hold = 0;
                while (hold < 4000) begin
                    @(posedge i_clk);
                    hold++;
                end
                long_hold = 0;
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= (!no_idle && $urandom_range(99) < 33);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    task automatic send_beat(t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        n_sent++;
        if (it.req_type == REQ_ADD) n_adds++;
        if (it.req_type == REQ_READ) n_reads++;
        if (!no_idle && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic reg_write(logic [3:0] addr, int unsigned val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(addr >> 2, val);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic configure(int unsigned bx, int unsigned by, int unsigned bz,
                             int unsigned w);
        drain();
        reg_write(ADDR_BOX_X, bx);
        reg_write(ADDR_BOX_Y, by);
        reg_write(ADDR_BOX_Z, bz);
        reg_write(ADDR_BINW, w);
    endtask

    function automatic t_in_item mk(logic [1:0] req, logic [1:0] ty,
                                    logic signed [19:0] x, logic signed [19:0] y,
                                    logic signed [19:0] z, logic [10:0] b,
                                    logic [3:0] k);
        t_in_item it;
        it.req_type = req;
        it.atom_type = ty;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.bin_index = b;
        it.pair_kind = k;
        return it;
    endfunction

    function automatic t_in_item rand_atom();
        t_in_item it;
        it = mk(REQ_ADD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        // half the atoms sit near the previous one to fill low bins
        if ($urandom_range(1)) begin
            it.pos_x = last_x + $signed(20'($urandom_range(600))) - 300;
            it.pos_y = last_y + $signed(20'($urandom_range(600))) - 300;
            it.pos_z = last_z + $signed(20'($urandom_range(600))) - 300;
        end
        return it;
    endfunction

    initial begin
        t_in_item it;
        int cap;
        sb = new();
        sb.reset_state();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        no_idle = 0;
        long_hold = 0;
        last_x = 0;
        last_y = 0;
        last_z = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: coordinate extremes, coincident atoms, reads, unused request, clear
        send_beat(mk(REQ_ADD, 2'd0, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 0, 0));
        send_beat(mk(REQ_ADD, 2'd3, -20'sh80000, -20'sh80000, -20'sh80000, 0, 0));
        send_beat(mk(REQ_ADD, 2'd1, 0, 0, 0, 0, 0));
        send_beat(mk(REQ_ADD, 2'd2, 0, 0, 0, 0, 0));
        send_beat(mk(REQ_ADD, 2'd1, 12620, -12620, 5, 0, 0));
        send_beat(mk(REQ_READ, 0, 0, 0, 0, 11'd0, 4'd6));
        send_beat(mk(REQ_READ, 0, 0, 0, 0, sb.hit_bin, sb.hit_kind));
        send_beat(mk(REQ_READ, 0, 0, 0, 0, 11'd2047, 4'd15));
        send_beat(mk(REQ_NOP, 2'd3, -1, -1, -1, 11'h7FF, 4'hF));
        send_beat(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
        send_beat(mk(REQ_READ, 0, 0, 0, 0, 11'd0, 4'd6));

        for (int seg = 0; seg < 8; seg++) begin
            case (seg)
                0: configure(25240, 25240, 25240, 20);
                1: configure(524287, 524287, 524287, 1);
                2: configure(1, 7, 1, 65535);
                3: configure(0, 0, 0, 0);
                default: configure($urandom_range(1000, 524287), $urandom_range(1000, 524287),
                                   $urandom_range(1000, 524287), $urandom_range(1, 400));
            endcase
            send_beat(mk(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom));
            cap = $urandom_range(20, 30);
            no_idle = (seg == 4);
            for (int n = 0; n < 134; n++) begin
                if (seg == 2 && n == 60) long_hold = 1;
                if (seg == 3 && n == 70) drain();
                if (sb.ax.size() < cap && $urandom_range(99) < 30) begin
                    it = rand_atom();
                    last_x = it.pos_x;
                    last_y = it.pos_y;
                    last_z = it.pos_z;
                end else if ($urandom_range(99) < 3) begin
                    it = mk(REQ_NOP, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom);
                end else begin
                    it = mk(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom);
                    if ($urandom_range(99) < 60) begin
                        it.bin_index = sb.hit_bin;
                        it.pair_kind = sb.hit_kind;
                    end
                end
                send_beat(it);
            end
        end
        no_idle = 0;
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d beats (%0d adds, %0d reads), %0d results checked",
                 n_sent, n_adds, n_reads, sb.n_checked);
        $display("over 8 register settings, %0d pairs beyond the last bin", sb.n_drops_seen);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/pdh_pkg.sv
rtl/pdh_ram.sv
rtl/pdh_dp.sv
rtl/pdh_ctrl.sv
rtl/pair_distance_histogram.sv
dv/pair_distance_histogram_test.sv
